@@ rtl/core/lsi_pkg.sv @@
package lsi_pkg;

	localparam int COORD_W  = 24;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int PROD_W   = 2 * DIFF_W;
	localparam int CROSS_W  = PROD_W + 1;
	localparam int S_FRAC   = 16;
	localparam int PARAM_W  = 32;
	localparam int NUM_W    = CROSS_W + S_FRAC;
	localparam int CMP_W    = CROSS_W + PARAM_W + 1;
	localparam int SPROD_W  = PARAM_W + DIFF_W;
	localparam int OFF_W    = SPROD_W - S_FRAC + 1;
	localparam int SUM_W    = OFF_W + 1;

	// Front stages, one per quotient bit, then saturate, multiply and add.
	localparam int FRONT_STAGES = 5;
	localparam int DIV_STEPS    = PARAM_W;
	localparam int NUM_STAGES   = FRONT_STAGES + DIV_STEPS + 3;

	typedef enum logic [1:0] {
		ST_DEGENERATE = 2'd0,
		ST_PARALLEL   = 2'd1,
		ST_COINCIDENT = 2'd2,
		ST_CROSSING   = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] dx;
		logic signed [COORD_W-1:0] dy;
	} query_t;

	typedef struct packed {
		status_t                   status;
		logic                      segments_cross;
		logic signed [PARAM_W-1:0] s_param;
		logic signed [PARAM_W-1:0] t_param;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
	} result_t;

endpackage

@@ rtl/core/line_segment_intersection.sv @@
// Intersection of line AB with line CD, one query per clock while query_stall is low. Five stages
// form the differences, cross products, magnitudes and classification, a 32-stage restoring
// divider yields one quotient bit of s and t per stage, and three stages saturate the parameters,
// multiply s by B-A and add A. Every stage only holds on a stall when the stage after it is
// also full, so empty slots close up and queries keep being taken while a result waits at the
// output.
module line_segment_intersection (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             query_valid,
	output logic             query_stall,
	input  lsi_pkg::query_t  query,
	output logic             result_valid,
	input  logic             result_stall,
	output lsi_pkg::result_t result
);

	localparam int NS = lsi_pkg::NUM_STAGES;
	localparam int FS = lsi_pkg::FRONT_STAGES;
	localparam int DS = lsi_pkg::DIV_STEPS;

	typedef struct packed {
		logic                              degen;
		logic signed [lsi_pkg::COORD_W-1:0] ax;
		logic signed [lsi_pkg::COORD_W-1:0] ay;
		logic signed [lsi_pkg::DIFF_W-1:0]  bax;
		logic signed [lsi_pkg::DIFF_W-1:0]  bay;
		logic signed [lsi_pkg::DIFF_W-1:0]  dcx;
		logic signed [lsi_pkg::DIFF_W-1:0]  dcy;
		logic signed [lsi_pkg::DIFF_W-1:0]  acx;
		logic signed [lsi_pkg::DIFF_W-1:0]  acy;
	} diff_t;

	typedef struct packed {
		logic                              degen;
		logic signed [lsi_pkg::COORD_W-1:0] ax;
		logic signed [lsi_pkg::COORD_W-1:0] ay;
		logic signed [lsi_pkg::DIFF_W-1:0]  bax;
		logic signed [lsi_pkg::DIFF_W-1:0]  bay;
		logic signed [lsi_pkg::PROD_W-1:0]  p_dcy_bax;
		logic signed [lsi_pkg::PROD_W-1:0]  p_dcx_bay;
		logic signed [lsi_pkg::PROD_W-1:0]  p_dcx_acy;
		logic signed [lsi_pkg::PROD_W-1:0]  p_dcy_acx;
		logic signed [lsi_pkg::PROD_W-1:0]  p_bax_acy;
		logic signed [lsi_pkg::PROD_W-1:0]  p_bay_acx;
	} prod_t;

	typedef struct packed {
		logic                              degen;
		logic signed [lsi_pkg::COORD_W-1:0] ax;
		logic signed [lsi_pkg::COORD_W-1:0] ay;
		logic signed [lsi_pkg::DIFF_W-1:0]  bax;
		logic signed [lsi_pkg::DIFF_W-1:0]  bay;
		logic signed [lsi_pkg::CROSS_W-1:0] den;
		logic signed [lsi_pkg::CROSS_W-1:0] sn;
		logic signed [lsi_pkg::CROSS_W-1:0] tn;
	} cross_t;

	typedef struct packed {
		logic                              degen;
		logic signed [lsi_pkg::COORD_W-1:0] ax;
		logic signed [lsi_pkg::COORD_W-1:0] ay;
		logic signed [lsi_pkg::DIFF_W-1:0]  bax;
		logic signed [lsi_pkg::DIFF_W-1:0]  bay;
		logic [lsi_pkg::CROSS_W-1:0]        den_mag;
		logic [lsi_pkg::CROSS_W-1:0]        sn_mag;
		logic [lsi_pkg::CROSS_W-1:0]        tn_mag;
		logic                              den_neg;
		logic                              sn_neg;
		logic                              tn_neg;
		logic                              den_zero;
		logic                              sn_zero;
		logic                              tn_zero;
	} mag_t;

	typedef struct packed {
		lsi_pkg::status_t                  status;
		logic                              seg_cross;
		logic signed [lsi_pkg::COORD_W-1:0] ax;
		logic signed [lsi_pkg::COORD_W-1:0] ay;
		logic signed [lsi_pkg::DIFF_W-1:0]  bax;
		logic signed [lsi_pkg::DIFF_W-1:0]  bay;
		logic [lsi_pkg::CROSS_W-1:0]        dmag;
		logic                              s_neg;
		logic                              t_neg;
		logic                              s_ovf;
		logic                              t_ovf;
		logic [lsi_pkg::NUM_W-1:0]          s_rem;
		logic [lsi_pkg::NUM_W-1:0]          t_rem;
		logic [lsi_pkg::PARAM_W-1:0]        s_quo;
		logic [lsi_pkg::PARAM_W-1:0]        t_quo;
	} div_t;

	typedef struct packed {
		lsi_pkg::status_t                  status;
		logic                              seg_cross;
		logic signed [lsi_pkg::COORD_W-1:0] ax;
		logic signed [lsi_pkg::COORD_W-1:0] ay;
		logic signed [lsi_pkg::DIFF_W-1:0]  bax;
		logic signed [lsi_pkg::DIFF_W-1:0]  bay;
		logic signed [lsi_pkg::PARAM_W-1:0] s_val;
		logic signed [lsi_pkg::PARAM_W-1:0] t_val;
	} sat_t;

	typedef struct packed {
		lsi_pkg::status_t                  status;
		logic                              seg_cross;
		logic signed [lsi_pkg::COORD_W-1:0] ax;
		logic signed [lsi_pkg::COORD_W-1:0] ay;
		logic signed [lsi_pkg::PARAM_W-1:0] s_val;
		logic signed [lsi_pkg::PARAM_W-1:0] t_val;
		logic signed [lsi_pkg::SPROD_W-1:0] px_prod;
		logic signed [lsi_pkg::SPROD_W-1:0] py_prod;
	} mul_t;

	logic [NS-1:0] valid_q;
	logic [NS:0]   en;

	diff_t            stage_s1;
	prod_t            stage_s2;
	cross_t           stage_s3;
	mag_t             stage_s4;
	div_t             div_s[0:DS];
	sat_t             stage_sat;
	mul_t             stage_mul;
	lsi_pkg::result_t stage_out;

	// A stage may load when it is empty or when its content moves on this cycle.
	assign en[NS] = !result_stall;
	genvar k;
	generate
		for (k = 0; k < NS; k++) begin : g_ctl
			assign en[k] = !valid_q[k] || en[k+1];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_q[k] <= 1'b0;
				end else if (en[k]) begin
					if (k == 0) begin
						valid_q[k] <= query_valid;
					end else begin
						valid_q[k] <= valid_q[(k == 0) ? 0 : k-1];
					end
				end
			end
		end
	endgenerate

	assign query_stall  = !en[0];
	assign result_valid = valid_q[NS-1];
	assign result       = stage_out;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			stage_s1.degen <= (query.ax == query.bx && query.ay == query.by) ||
				(query.cx == query.dx && query.cy == query.dy);
			stage_s1.ax  <= query.ax;
			stage_s1.ay  <= query.ay;
			stage_s1.bax <= lsi_pkg::DIFF_W'(query.bx) - lsi_pkg::DIFF_W'(query.ax);
			stage_s1.bay <= lsi_pkg::DIFF_W'(query.by) - lsi_pkg::DIFF_W'(query.ay);
			stage_s1.dcx <= lsi_pkg::DIFF_W'(query.dx) - lsi_pkg::DIFF_W'(query.cx);
			stage_s1.dcy <= lsi_pkg::DIFF_W'(query.dy) - lsi_pkg::DIFF_W'(query.cy);
			stage_s1.acx <= lsi_pkg::DIFF_W'(query.ax) - lsi_pkg::DIFF_W'(query.cx);
			stage_s1.acy <= lsi_pkg::DIFF_W'(query.ay) - lsi_pkg::DIFF_W'(query.cy);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			stage_s2.degen     <= stage_s1.degen;
			stage_s2.ax        <= stage_s1.ax;
			stage_s2.ay        <= stage_s1.ay;
			stage_s2.bax       <= stage_s1.bax;
			stage_s2.bay       <= stage_s1.bay;
			stage_s2.p_dcy_bax <= stage_s1.dcy * stage_s1.bax;
			stage_s2.p_dcx_bay <= stage_s1.dcx * stage_s1.bay;
			stage_s2.p_dcx_acy <= stage_s1.dcx * stage_s1.acy;
			stage_s2.p_dcy_acx <= stage_s1.dcy * stage_s1.acx;
			stage_s2.p_bax_acy <= stage_s1.bax * stage_s1.acy;
			stage_s2.p_bay_acx <= stage_s1.bay * stage_s1.acx;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			stage_s3.degen <= stage_s2.degen;
			stage_s3.ax    <= stage_s2.ax;
			stage_s3.ay    <= stage_s2.ay;
			stage_s3.bax   <= stage_s2.bax;
			stage_s3.bay   <= stage_s2.bay;
			stage_s3.den   <= lsi_pkg::CROSS_W'(stage_s2.p_dcy_bax) -
				lsi_pkg::CROSS_W'(stage_s2.p_dcx_bay);
			stage_s3.sn    <= lsi_pkg::CROSS_W'(stage_s2.p_dcx_acy) -
				lsi_pkg::CROSS_W'(stage_s2.p_dcy_acx);
			stage_s3.tn    <= lsi_pkg::CROSS_W'(stage_s2.p_bax_acy) -
				lsi_pkg::CROSS_W'(stage_s2.p_bay_acx);
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			stage_s4.degen    <= stage_s3.degen;
			stage_s4.ax       <= stage_s3.ax;
			stage_s4.ay       <= stage_s3.ay;
			stage_s4.bax      <= stage_s3.bax;
			stage_s4.bay      <= stage_s3.bay;
			stage_s4.den_mag  <= stage_s3.den[lsi_pkg::CROSS_W-1] ? -stage_s3.den : stage_s3.den;
			stage_s4.sn_mag   <= stage_s3.sn[lsi_pkg::CROSS_W-1] ? -stage_s3.sn : stage_s3.sn;
			stage_s4.tn_mag   <= stage_s3.tn[lsi_pkg::CROSS_W-1] ? -stage_s3.tn : stage_s3.tn;
			stage_s4.den_neg  <= stage_s3.den[lsi_pkg::CROSS_W-1];
			stage_s4.sn_neg   <= stage_s3.sn[lsi_pkg::CROSS_W-1];
			stage_s4.tn_neg   <= stage_s3.tn[lsi_pkg::CROSS_W-1];
			stage_s4.den_zero <= stage_s3.den == '0;
			stage_s4.sn_zero  <= stage_s3.sn == '0;
			stage_s4.tn_zero  <= stage_s3.tn == '0;
		end
	end

	// Classification, exact range test and quotient overflow check.
	logic [lsi_pkg::NUM_W-1:0] s_num, t_num;
	logic [lsi_pkg::CMP_W-1:0] d_top;
	logic                      s_unit, t_unit;
	lsi_pkg::status_t          status_c;

	always_comb begin
		s_num = {stage_s4.sn_mag, {lsi_pkg::S_FRAC{1'b0}}};
		t_num = {stage_s4.tn_mag, {lsi_pkg::S_FRAC{1'b0}}};
		d_top = {1'b0, stage_s4.den_mag, {lsi_pkg::PARAM_W{1'b0}}};
		s_unit = stage_s4.sn_zero ||
			(stage_s4.sn_neg == stage_s4.den_neg && stage_s4.den_mag >= stage_s4.sn_mag);
		t_unit = stage_s4.tn_zero ||
			(stage_s4.tn_neg == stage_s4.den_neg && stage_s4.den_mag >= stage_s4.tn_mag);
		if (stage_s4.degen) begin
			status_c = lsi_pkg::ST_DEGENERATE;
		end else if (stage_s4.den_zero) begin
			status_c = (stage_s4.sn_zero || stage_s4.tn_zero) ?
				lsi_pkg::ST_COINCIDENT : lsi_pkg::ST_PARALLEL;
		end else begin
			status_c = lsi_pkg::ST_CROSSING;
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			div_s[0].status    <= status_c;
			div_s[0].seg_cross <= (status_c == lsi_pkg::ST_COINCIDENT) ||
				(status_c == lsi_pkg::ST_CROSSING && s_unit && t_unit);
			div_s[0].ax        <= stage_s4.ax;
			div_s[0].ay        <= stage_s4.ay;
			div_s[0].bax       <= stage_s4.bax;
			div_s[0].bay       <= stage_s4.bay;
			div_s[0].dmag      <= stage_s4.den_mag;
			div_s[0].s_neg     <= stage_s4.sn_neg ^ stage_s4.den_neg;
			div_s[0].t_neg     <= stage_s4.tn_neg ^ stage_s4.den_neg;
			div_s[0].s_ovf     <= lsi_pkg::CMP_W'(s_num) >= d_top;
			div_s[0].t_ovf     <= lsi_pkg::CMP_W'(t_num) >= d_top;
			div_s[0].s_rem     <= s_num;
			div_s[0].t_rem     <= t_num;
			div_s[0].s_quo     <= '0;
			div_s[0].t_quo     <= '0;
		end
	end

	// One quotient bit per stage, most significant first.
	generate
		for (k = 0; k < DS; k++) begin : g_div
			localparam int BIT = DS - 1 - k;
			logic [lsi_pkg::CMP_W-1:0] dsh;
			logic                      s_ge, t_ge;
			div_t                      div_nxt;
			assign dsh  = lsi_pkg::CMP_W'(div_s[k].dmag) << BIT;
			assign s_ge = lsi_pkg::CMP_W'(div_s[k].s_rem) >= dsh;
			assign t_ge = lsi_pkg::CMP_W'(div_s[k].t_rem) >= dsh;
			always_comb begin
				div_nxt            = div_s[k];
				div_nxt.s_quo[BIT] = s_ge;
				div_nxt.t_quo[BIT] = t_ge;
				if (s_ge) begin
					div_nxt.s_rem = div_s[k].s_rem - dsh[lsi_pkg::NUM_W-1:0];
				end
				if (t_ge) begin
					div_nxt.t_rem = div_s[k].t_rem - dsh[lsi_pkg::NUM_W-1:0];
				end
			end
			always_ff @(posedge clk) begin
				if (en[FS+k]) begin
					div_s[k+1] <= div_nxt;
				end
			end
		end
	endgenerate

	function automatic logic signed [lsi_pkg::PARAM_W-1:0] sat_quo(
		input logic ovf, input logic neg, input logic [lsi_pkg::PARAM_W-1:0] q);
		logic [lsi_pkg::PARAM_W-1:0] lim;
		lim = {1'b1, {(lsi_pkg::PARAM_W-1){1'b0}}};
		if (neg) begin
			sat_quo = (ovf || q > lim) ? lim : -q;
		end else begin
			sat_quo = (ovf || q[lsi_pkg::PARAM_W-1]) ? ~lim : q;
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en[FS+DS]) begin
			stage_sat.status    <= div_s[DS].status;
			stage_sat.seg_cross <= div_s[DS].seg_cross;
			stage_sat.ax        <= div_s[DS].ax;
			stage_sat.ay        <= div_s[DS].ay;
			stage_sat.bax       <= div_s[DS].bax;
			stage_sat.bay       <= div_s[DS].bay;
			stage_sat.s_val     <= sat_quo(div_s[DS].s_ovf, div_s[DS].s_neg, div_s[DS].s_quo);
			stage_sat.t_val     <= sat_quo(div_s[DS].t_ovf, div_s[DS].t_neg, div_s[DS].t_quo);
		end
	end

	always_ff @(posedge clk) begin
		if (en[FS+DS+1]) begin
			stage_mul.status    <= stage_sat.status;
			stage_mul.seg_cross <= stage_sat.seg_cross;
			stage_mul.ax        <= stage_sat.ax;
			stage_mul.ay        <= stage_sat.ay;
			stage_mul.s_val     <= stage_sat.s_val;
			stage_mul.t_val     <= stage_sat.t_val;
			stage_mul.px_prod   <= stage_sat.s_val * stage_sat.bax;
			stage_mul.py_prod   <= stage_sat.s_val * stage_sat.bay;
		end
	end

	// The offset is truncated toward zero, then added to A and clamped.
	function automatic logic signed [lsi_pkg::COORD_W-1:0] point_coord(
		input logic signed [lsi_pkg::COORD_W-1:0] a,
		input logic signed [lsi_pkg::SPROD_W-1:0] p);
		logic [lsi_pkg::SPROD_W-1:0]       mag;
		logic signed [lsi_pkg::OFF_W-1:0]  off;
		logic signed [lsi_pkg::SUM_W-1:0]  sum;
		logic signed [lsi_pkg::SUM_W-1:0]  hi;
		logic signed [lsi_pkg::SUM_W-1:0]  lo;
		mag = p[lsi_pkg::SPROD_W-1] ? -p : p;
		off = $signed({1'b0, mag[lsi_pkg::SPROD_W-1:lsi_pkg::S_FRAC]});
		if (p[lsi_pkg::SPROD_W-1]) begin
			off = -off;
		end
		sum = lsi_pkg::SUM_W'(a) + lsi_pkg::SUM_W'(off);
		hi  = lsi_pkg::SUM_W'({1'b0, {(lsi_pkg::COORD_W-1){1'b1}}});
		lo  = -hi - lsi_pkg::SUM_W'(1);
		if (sum > hi) begin
			point_coord = hi[lsi_pkg::COORD_W-1:0];
		end else if (sum < lo) begin
			point_coord = lo[lsi_pkg::COORD_W-1:0];
		end else begin
			point_coord = sum[lsi_pkg::COORD_W-1:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			stage_out.status         <= stage_mul.status;
			stage_out.segments_cross <= stage_mul.seg_cross;
			case (stage_mul.status)
				lsi_pkg::ST_CROSSING: begin
					stage_out.s_param <= stage_mul.s_val;
					stage_out.t_param <= stage_mul.t_val;
					stage_out.point_x <= point_coord(stage_mul.ax, stage_mul.px_prod);
					stage_out.point_y <= point_coord(stage_mul.ay, stage_mul.py_prod);
				end
				lsi_pkg::ST_COINCIDENT: begin
					stage_out.s_param <= '0;
					stage_out.t_param <= '0;
					stage_out.point_x <= stage_mul.ax;
					stage_out.point_y <= stage_mul.ay;
				end
				default: begin
					stage_out.s_param <= '0;
					stage_out.t_param <= '0;
					stage_out.point_x <= '0;
					stage_out.point_y <= '0;
				end
			endcase
		end
	end

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == lsi_pkg::ST_DEGENERATE |->
			!result.segments_cross && result.s_param == 0 && result.point_x == 0)
		else $error("degenerate result carries non-zero fields");

	a_coincident_cross: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == lsi_pkg::ST_COINCIDENT |->
			result.segments_cross && result.t_param == 0)
		else $error("coincident result not flagged as crossing");

	a_parallel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == lsi_pkg::ST_PARALLEL |->
			!result.segments_cross && result.point_y == 0)
		else $error("parallel result carries non-zero fields");

endmodule

@@ sim/line_segment_intersection_tb.sv @@
`timescale 1ns / 1ps

module line_segment_intersection_tb;

	localparam int IDLE_LIMIT = 20000;
	localparam int TAIL_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic query_valid = 1'b0;
	logic query_stall;
	lsi_pkg::query_t query = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	lsi_pkg::result_t result;

	lsi_pkg::result_t expected_q[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit sender_idles = 1'b1;
	bit receiver_idles = 1'b1;

	line_segment_intersection dut (
		.clk(clk),
		.arst_n(arst_n),
		.query_valid(query_valid),
		.query_stall(query_stall),
		.query(query),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Exact quotient num/den in Q15.16, truncated toward zero and saturated.
	function automatic logic signed [31:0] fixed_quotient(logic signed [127:0] num,
			logic signed [127:0] den);
		logic [127:0] mag_n;
		logic [127:0] mag_d;
		logic [127:0] q;
		bit neg;
		neg = (num < 0) != (den < 0);
		mag_n = (num < 0) ? -num : num;
		mag_d = (den < 0) ? -den : den;
		q = (mag_n << 16) / mag_d;
		if (!neg)
			return (q > 128'h7FFFFFFF) ? 32'sh7FFFFFFF : q[31:0];
		if (q > 128'h80000000)
			return 32'sh80000000;
		return -q[31:0];
	endfunction

	function automatic bit in_unit_range(logic signed [127:0] num, logic signed [127:0] den);
		logic signed [127:0] mag_n;
		logic signed [127:0] mag_d;
		mag_n = (num < 0) ? -num : num;
		mag_d = (den < 0) ? -den : den;
		if (num == 0)
			return 1'b1;
		if ((num < 0) != (den < 0))
			return 1'b0;
		return mag_d >= mag_n;
	endfunction

	function automatic logic signed [23:0] point_coord(logic signed [63:0] a,
			logic signed [31:0] s, logic signed [63:0] delta);
		logic signed [127:0] p;
		logic [127:0] m;
		logic signed [127:0] r;
		p = 128'(s) * 128'(delta);
		m = (p < 0) ? -p : p;
		m = m >> 16;
		r = 128'(a) + ((p < 0) ? -$signed(m) : $signed(m));
		if (r > 128'sd8388607)
			r = 128'sd8388607;
		if (r < -128'sd8388608)
			r = -128'sd8388608;
		return r[23:0];
	endfunction

	function automatic lsi_pkg::result_t predict_intersection(lsi_pkg::query_t q);
		lsi_pkg::result_t r;
		logic signed [127:0] bax, bay, dcx, dcy, acx, acy, den, sn, tn;
		r = '0;
		r.status = lsi_pkg::ST_DEGENERATE;
		if (!((q.ax == q.bx && q.ay == q.by) || (q.cx == q.dx && q.cy == q.dy))) begin
			bax = 128'(q.bx) - 128'(q.ax);
			bay = 128'(q.by) - 128'(q.ay);
			dcx = 128'(q.dx) - 128'(q.cx);
			dcy = 128'(q.dy) - 128'(q.cy);
			acx = 128'(q.ax) - 128'(q.cx);
			acy = 128'(q.ay) - 128'(q.cy);
			den = dcy * bax - dcx * bay;
			sn = dcx * acy - dcy * acx;
			tn = bax * acy - bay * acx;
			if (den == 0) begin
				if (sn == 0 || tn == 0) begin
					r.status = lsi_pkg::ST_COINCIDENT;
					r.segments_cross = 1'b1;
					r.point_x = q.ax;
					r.point_y = q.ay;
				end else begin
					r.status = lsi_pkg::ST_PARALLEL;
				end
			end else begin
				r.status = lsi_pkg::ST_CROSSING;
				r.s_param = fixed_quotient(sn, den);
				r.t_param = fixed_quotient(tn, den);
				r.segments_cross = in_unit_range(sn, den) && in_unit_range(tn, den);
				r.point_x = point_coord(64'(q.ax), r.s_param, 64'(bax));
				r.point_y = point_coord(64'(q.ay), r.s_param, 64'(bay));
			end
		end
		return r;
	endfunction

	// Valid stays high after an item so that the next one can follow without a gap.
	task automatic send_query(lsi_pkg::query_t q);
		while (sender_idles && $urandom_range(99) < 35) begin
			query_valid <= 1'b0;
			@(negedge clk);
		end
		query <= q;
		query_valid <= 1'b1;
		@(posedge clk);
		while (query_stall)
			@(posedge clk);
		expected_q.push_back(predict_intersection(q));
		@(negedge clk);
	endtask

	// Coordinates: mostly small values so that ranges and parallels are hit, some full width.
	function automatic logic signed [23:0] rand_coord();
		case ($urandom_range(3))
			0: return 24'($urandom);
			1: return $signed(24'($urandom_range(255))) - 24'sd128;
			2: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
			default: return $signed(24'($urandom_range(8191))) - 24'sd4096;
		endcase
	endfunction

	function automatic lsi_pkg::query_t rand_query();
		lsi_pkg::query_t q;
		int k;
		q = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord(), rand_coord()};
		k = $urandom_range(9);
		if (k == 0) begin
			q.bx = q.ax;
			q.by = q.ay;
		end else if (k == 1) begin
			// Parallel or coincident: CD is a multiple of AB.
			q.dx = 24'(q.cx + (q.bx - q.ax) * ($urandom_range(1) ? 1 : -2));
			q.dy = 24'(q.cy + (q.by - q.ay) * ($urandom_range(1) ? 1 : -2));
			if ($urandom_range(1)) begin
				q.cx = q.ax;
				q.cy = q.ay;
				q.dx = q.bx;
				q.dy = q.by;
			end
		end
		return q;
	endfunction

	task automatic test_extremes();
		lsi_pkg::query_t q;
		send_query({24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF,
			24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000});
		send_query({24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF,
			24'sh000000, 24'sh000000, 24'sh000001, 24'sh000001});
		send_query({24'sh800000, 24'sh000000, 24'sh7FFFFF, 24'sh000001,
			24'sh000000, 24'sh800000, 24'sh000001, 24'sh7FFFFF});
		send_query({8{24'shFFFFFF}});
		q = {24'sd0, 24'sd0, 24'sd1, 24'sd0, 24'sh7FFFFF, 24'sd1, 24'sh7FFFFF, 24'sd2};
		send_query(q);
		send_query({24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000,
			24'sh800000, 24'sh800000, 24'sh800001, 24'sh800000});
	endtask

	task automatic test_special_cases();
		// Degenerate on either side.
		send_query({24'sd5, 24'sd5, 24'sd5, 24'sd5, 24'sd0, 24'sd0, 24'sd9, 24'sd1});
		send_query({24'sd0, 24'sd0, 24'sd9, 24'sd1, -24'sd3, 24'sd7, -24'sd3, 24'sd7});
		// Parallel and distinct, coincident, coincident but disjoint.
		send_query({24'sd0, 24'sd0, 24'sd256, 24'sd0, 24'sd0, 24'sd256, 24'sd512, 24'sd256});
		send_query({24'sd0, 24'sd0, 24'sd256, 24'sd256, 24'sd512, 24'sd512, -24'sd256, -24'sd256});
		send_query({24'sd0, 24'sd0, 24'sd1, 24'sd1, 24'sd900, 24'sd900, 24'sd901, 24'sd901});
		// Crossing inside, at an end point, and outside the segments.
		send_query({24'sd0, 24'sd0, 24'sd512, 24'sd512, 24'sd0, 24'sd512, 24'sd512, 24'sd0});
		send_query({24'sd0, 24'sd0, 24'sd512, 24'sd0, 24'sd512, -24'sd100, 24'sd512, 24'sd100});
		send_query({24'sd0, 24'sd0, 24'sd1, 24'sd0, 24'sd500, -24'sd1, 24'sd500, 24'sd1});
		send_query({24'sd0, 24'sd0, 24'sd1, 24'sd0, -24'sd500, -24'sd1, -24'sd500, 24'sd1});
		// Quotients that saturate on both sides, and a non-exact third.
		send_query({24'sd0, 24'sd0, 24'sd1, 24'sd0, 24'sh7FFFFF, 24'sd0, 24'sh7FFFFF, 24'sd1});
		send_query({24'sd0, 24'sd0, 24'sd1, 24'sd0, 24'sh800000, 24'sd0, 24'sh800000, 24'sd1});
		send_query({24'sd0, 24'sd0, 24'sd3, 24'sd0, 24'sd1, -24'sd1, 24'sd1, 24'sd1});
	endtask

	task automatic wait_drained();
		query_valid <= 1'b0;
		@(negedge clk);
		while (expected_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				wait_drained();
			send_query(rand_query());
		end
	endtask

	task automatic test_back_to_back(int count);
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		for (int i = 0; i < count; i++)
			send_query(rand_query());
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
	endtask

	always @(negedge clk)
		result_stall <= receiver_idles && ($urandom_range(99) < 35);

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result %p", result);
			end else if (result !== expected_q[0]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Expected %p, got %p", expected_q[0], result);
				void'(expected_q.pop_front());
			end else begin
				void'(expected_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((query_valid && !query_stall) || (result_valid && !result_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes();
		test_special_cases();
		test_random(1000);
		test_back_to_back(300);
		test_random(230);
		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
